>>> rtl/color_gaussian_window_filter_defines.svh
// Assertion macros for the window filter RTL.
`ifndef COLOR_GAUSSIAN_WINDOW_FILTER_DEFINES_SVH
`define COLOR_GAUSSIAN_WINDOW_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GWF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GWF_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gwf_pkg.sv
// Shared constants and types of the Gaussian window filter.
package gwf_pkg;

    localparam int MAX_RADIUS_DEF = 3;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PX_W       = CH_W * NUM_CH;
    localparam int WGT_W      = 16;
    localparam int PROD_W     = 2 * WGT_W;
    localparam int QUOT_W     = CH_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int RAD_CFG_W  = 2;
    localparam int MODE_CFG_W = 2;
    localparam int WID_CFG_W  = 11;
    localparam int HGT_CFG_W  = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VWEIGHTS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HWEIGHTS = 3'd5;

    localparam logic [MODE_CFG_W-1:0] MODE_ZERO   = 2'd0;
    localparam logic [MODE_CFG_W-1:0] MODE_MIRROR = 2'd1;
    localparam logic [MODE_CFG_W-1:0] MODE_ADJUST = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic [CH_W-1:0] chan_t;

endpackage

>>> rtl/color_gaussian_window_filter.sv
// Top level of the RGB Gaussian window filter with line store and tap sequencer.
//
//  Channel  Direction  Signals                        Payload
//  s_*      in         s_tvalid s_tready s_tdata      tdata: blue, green, red; tuser: op
//                      s_tuser
//  m_*      out        m_tvalid m_tready m_tdata      tdata: blue, green, red; tlast: frame_end
//                      m_tlast
//  cfg_*    in         cfg_we cfg_index cfg_data      register writes, no read-back
//
// A frame-starting input transfer samples the registers in ST_LATCH1 and derives the frame
// lag and size in ST_LATCH2. A pixel that gives no result only passes ST_STEP; one that
// gives a result runs ST_TAP_A, ST_TAP_R and ST_TAP_C for every tap (one line-store read
// per tap), waits in ST_DIV for the division chain and reaches the output register through
// ST_OUT. Reset clears the sequencer, the frame counters and the output valid; the line
// store itself is not cleared, since every used tap reads an entry written in the frame.
// A result waits in the output register while the next input transfer is taken;
// the sequencer only stalls if a second result is ready before the first has left.
`include "color_gaussian_window_filter_defines.svh"

module color_gaussian_window_filter
    import gwf_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PX_W-1:0]        s_tdata,   // [7:0] blue_in, [15:8] green_in, [23:16] red_in
    input  logic [0:0]             s_tuser,   // [0] op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [PX_W-1:0]        m_tdata,   // [7:0] blue_out, [15:8] green_out, [23:16] red_out
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Sizes that follow from the maximum frame and window.
    localparam int RW          = $clog2(MAX_RADIUS + 1);
    localparam int OFS_W       = RW + 1;
    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int HW          = $clog2(MAX_HEIGHT + 1);
    localparam int PS          = ((HW > WW) ? HW : WW) + 2;
    localparam int LIN_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int OFFW        = AW + 2;
    localparam int TAPS        = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int DEN_W       = PROD_W + $clog2(TAPS + 1);
    localparam int SUM_W       = DEN_W + CH_W;

    localparam logic signed [OFFW-1:0] DEPTH_S = OFFW'(STORE_DEPTH);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LATCH1 = 4'd1;
    localparam logic [3:0] ST_LATCH2 = 4'd2;
    localparam logic [3:0] ST_STEP   = 4'd3;
    localparam logic [3:0] ST_TAP_A  = 4'd4;
    localparam logic [3:0] ST_TAP_R  = 4'd5;
    localparam logic [3:0] ST_TAP_C  = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    // Configuration registers as written.
    logic [RAD_CFG_W-1:0]   radius_reg;
    logic [MODE_CFG_W-1:0]  mode_cfg_reg;
    logic [WID_CFG_W-1:0]   width_cfg_reg;
    logic [HGT_CFG_W-1:0]   height_cfg_reg;
    logic [CFG_DATA_W-1:0]  vweights_reg;
    logic [CFG_DATA_W-1:0]  hweights_reg;

    // Copy of the registers taken when a frame starts.
    logic [RW-1:0]          fr_rad_reg;
    logic [MODE_CFG_W-1:0]  fr_mode_reg;
    logic [WW-1:0]          fr_w_reg;
    logic [HW-1:0]          fr_h_reg;
    logic [WGT_W-1:0]       vw_reg [MAX_RADIUS+1];
    logic [WGT_W-1:0]       hw_reg [MAX_RADIUS+1];
    logic [LIN_W-1:0]       lag_reg;
    logic [LIN_W-1:0]       total_reg;

    // Sequencer and frame position.
    logic [3:0]             state_reg;
    logic [3:0]             state_next;
    logic                   active_reg;
    logic [WW-1:0]          in_col_reg;
    logic [HW-1:0]          in_row_reg;
    logic [LIN_W-1:0]       in_lin_reg;
    logic [AW-1:0]          in_addr_reg;
    logic [WW-1:0]          out_col_reg;
    logic [HW-1:0]          out_row_reg;
    logic [LIN_W-1:0]       out_lin_reg;
    logic [AW-1:0]          out_addr_reg;

    // Held input transfer.
    logic                   pend_op_reg;
    logic [PX_W-1:0]        pend_px_reg;

    // Tap loop.
    logic signed [OFS_W-1:0] a_reg;
    logic signed [OFS_W-1:0] b_reg;
    logic [AW-1:0]           tap_addr_reg;
    logic [PROD_W-1:0]       w_reg;
    logic                    tap_use_reg;
    logic                    tap_in_reg;
    logic [PX_W-1:0]         rd_data_reg;
    logic [NUM_CH-1:0][SUM_W-1:0] sum_reg;
    logic [DEN_W-1:0]        wall_reg;
    logic [DEN_W-1:0]        win_reg;
    logic [DEN_W-1:0]        denom_reg;
    logic                    div_start_reg;

    // Output register.
    logic                    m_tvalid_reg;
    logic [PX_W-1:0]         m_tdata_reg;
    logic                    m_tlast_reg;
    logic [PX_W-1:0]         res_px_reg;
    logic                    res_last_reg;

    logic [PX_W-1:0]         line_mem [STORE_DEPTH];

    // Combinational helpers.
    logic                    s_xfer;
    logic                    in_done;
    logic                    emit_ok;
    logic                    out_last;
    logic                    out_free;
    logic                    emit_go;
    logic                    mem_we;
    logic                    tap_last;
    logic signed [OFS_W-1:0] rad_s;
    logic [RW-1:0]           rad_c;
    logic [WW-1:0]           w_c;
    logic [HW-1:0]           h_c;
    logic [MODE_CFG_W-1:0]   mode_c;
    logic signed [PS-1:0]    r_s;
    logic signed [PS-1:0]    c_s;
    logic signed [PS-1:0]    h_s;
    logic signed [PS-1:0]    w_s;
    logic signed [PS-1:0]    tr;
    logic signed [PS-1:0]    tc;
    logic signed [PS-1:0]    dr;
    logic signed [PS-1:0]    dc;
    logic signed [OFFW-1:0]  off;
    logic signed [OFFW-1:0]  asum;
    logic                    tap_in;
    logic                    tap_use;
    logic [AW-1:0]           tap_addr;
    logic [RW-1:0]           a_abs;
    logic [RW-1:0]           b_abs;
    logic                    div_done;
    chan_t [NUM_CH-1:0]      quot;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign in_done  = (in_row_reg >= fr_h_reg);
    assign emit_ok  = ((LIN_W+1)'(in_lin_reg) >=
                       (LIN_W+1)'(out_lin_reg) + (LIN_W+1)'(lag_reg));
    assign out_last = ((LIN_W+1)'(out_lin_reg) + (LIN_W+1)'(1) >= (LIN_W+1)'(total_reg));
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_go  = (state_reg == ST_STEP) && (in_done || (pend_op_reg == OP_PIXEL && emit_ok));
    assign mem_we   = (state_reg == ST_STEP) && !in_done && (pend_op_reg == OP_PIXEL);
    assign rad_s    = $signed(OFS_W'(fr_rad_reg));
    assign tap_last = (a_reg == rad_s) && (b_reg == rad_s);

    // Register sampling at frame start: radius, width and height are clamped
    // into their legal ranges and the unused mode code falls back to zero padding.
    always_comb
    begin
        if (radius_reg == '0)
        begin
            rad_c = RW'(1);
        end
        else if (32'(radius_reg) > MAX_RADIUS)
        begin
            rad_c = RW'(MAX_RADIUS);
        end
        else
        begin
            rad_c = RW'(radius_reg);
        end

        if (32'(width_cfg_reg) < 32'(rad_c) * 2 + 1)
        begin
            w_c = WW'(32'(rad_c) * 2 + 1);
        end
        else if (32'(width_cfg_reg) > MAX_WIDTH)
        begin
            w_c = WW'(MAX_WIDTH);
        end
        else
        begin
            w_c = WW'(width_cfg_reg);
        end

        if (32'(height_cfg_reg) < 32'(rad_c) * 2 + 1)
        begin
            h_c = HW'(32'(rad_c) * 2 + 1);
        end
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
        begin
            h_c = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_c = HW'(height_cfg_reg);
        end

        mode_c = (mode_cfg_reg == MODE_ZERO || mode_cfg_reg == MODE_MIRROR ||
                  mode_cfg_reg == MODE_ADJUST) ? mode_cfg_reg : MODE_ZERO;
    end

    // Tap position. Mirroring folds a row or column off the far edge back across the
    // centre and one below zero back across zero; a tap still outside the image is skipped.
    // The store address is the centre address plus the signed offset, wrapped once.
    always_comb
    begin
        r_s = $signed(PS'(out_row_reg));
        c_s = $signed(PS'(out_col_reg));
        h_s = $signed(PS'(fr_h_reg));
        w_s = $signed(PS'(fr_w_reg));
        tr  = r_s + PS'(a_reg);
        tc  = c_s + PS'(b_reg);
        tap_in = (tr >= 0) && (tr < h_s) && (tc >= 0) && (tc < w_s);
        if (fr_mode_reg == MODE_MIRROR)
        begin
            if (tr > h_s - PS'(1))
            begin
                tr = r_s - PS'(a_reg);
            end
            else if (tr < 0)
            begin
                tr = -tr;
            end
            if (tc > w_s - PS'(1))
            begin
                tc = c_s - PS'(b_reg);
            end
            else if (tc < 0)
            begin
                tc = -tc;
            end
            tap_use = (tr >= 0) && (tr < h_s) && (tc >= 0) && (tc < w_s);
        end
        else
        begin
            tap_use = tap_in;
        end
        dr   = tr - r_s;
        dc   = tc - c_s;
        off  = OFFW'(dr) * OFFW'(w_s) + OFFW'(dc);
        asum = $signed(OFFW'(out_addr_reg)) + off;
        if (asum < 0)
        begin
            asum = asum + DEPTH_S;
        end
        else if (asum >= DEPTH_S)
        begin
            asum = asum - DEPTH_S;
        end
        tap_addr = asum[AW-1:0];
        a_abs = (a_reg < 0) ? RW'(-a_reg) : RW'(a_reg);
        b_abs = (b_reg < 0) ? RW'(-b_reg) : RW'(b_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    if (active_reg)
                    begin
                        state_next = ST_STEP;
                    end
                    else if (s_tuser[0] == OP_PIXEL)
                    begin
                        state_next = ST_LATCH1;
                    end
                end
            end
            ST_LATCH1: state_next = ST_LATCH2;
            ST_LATCH2: state_next = ST_STEP;
            ST_STEP:   state_next = emit_go ? ST_TAP_A : ST_IDLE;
            ST_TAP_A:  state_next = ST_TAP_R;
            ST_TAP_R:  state_next = ST_TAP_C;
            ST_TAP_C:  state_next = tap_last ? ST_DIV : ST_TAP_A;
            ST_DIV:    state_next = div_done ? ST_OUT : ST_DIV;
            ST_OUT:    state_next = out_free ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state: sequencer, frame counters, output valid and the registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= 1'b0;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            in_lin_reg     <= '0;
            in_addr_reg    <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_lin_reg    <= '0;
            out_addr_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            div_start_reg  <= 1'b0;
            radius_reg     <= RAD_CFG_W'(1);
            mode_cfg_reg   <= MODE_ZERO;
            width_cfg_reg  <= WID_CFG_W'(512);
            height_cfg_reg <= HGT_CFG_W'(512);
            vweights_reg   <= '0;
            hweights_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= (state_reg == ST_TAP_C) && tap_last;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RADIUS:   radius_reg     <= cfg_data[RAD_CFG_W-1:0];
                    CFG_MODE:     mode_cfg_reg   <= cfg_data[MODE_CFG_W-1:0];
                    CFG_WIDTH:    width_cfg_reg  <= cfg_data[WID_CFG_W-1:0];
                    CFG_HEIGHT:   height_cfg_reg <= cfg_data[HGT_CFG_W-1:0];
                    CFG_VWEIGHTS: vweights_reg   <= cfg_data;
                    CFG_HWEIGHTS: hweights_reg   <= cfg_data;
                    default:      ;
                endcase
            end

            if (s_xfer && !active_reg && s_tuser[0] == OP_PIXEL)
            begin
                active_reg <= 1'b1;
            end

            if (mem_we)
            begin
                in_lin_reg  <= in_lin_reg + LIN_W'(1);
                in_addr_reg <= (in_addr_reg == AW'(STORE_DEPTH - 1)) ? '0
                               : in_addr_reg + AW'(1);
                if (in_col_reg + WW'(1) == fr_w_reg)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + HW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + WW'(1);
                end
            end

            // A new result takes the output register; otherwise a taken result leaves it.
            if (state_reg == ST_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (state_reg == ST_OUT && out_free)
            begin
                if (res_last_reg)
                begin
                    // Last pixel of the frame: everything returns to the start.
                    active_reg   <= 1'b0;
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_lin_reg   <= '0;
                    in_addr_reg  <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_lin_reg  <= '0;
                    out_addr_reg <= '0;
                end
                else
                begin
                    out_lin_reg  <= out_lin_reg + LIN_W'(1);
                    out_addr_reg <= (out_addr_reg == AW'(STORE_DEPTH - 1)) ? '0
                                    : out_addr_reg + AW'(1);
                    if (out_col_reg + WW'(1) == fr_w_reg)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + HW'(1);
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + WW'(1);
                    end
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            pend_op_reg <= s_tuser[0];
            pend_px_reg <= s_tdata;
        end

        if (state_reg == ST_LATCH1)
        begin
            fr_rad_reg  <= rad_c;
            fr_w_reg    <= w_c;
            fr_h_reg    <= h_c;
            fr_mode_reg <= mode_c;
            for (int d = 0; d <= MAX_RADIUS; d++)
            begin
                vw_reg[d] <= vweights_reg[WGT_W*d +: WGT_W];
                hw_reg[d] <= hweights_reg[WGT_W*d +: WGT_W];
            end
        end

        if (state_reg == ST_LATCH2)
        begin
            lag_reg   <= LIN_W'(fr_rad_reg) * LIN_W'(fr_w_reg) + LIN_W'(fr_rad_reg);
            total_reg <= LIN_W'(fr_w_reg) * LIN_W'(fr_h_reg);
        end

        if (emit_go)
        begin
            a_reg    <= -rad_s;
            b_reg    <= -rad_s;
            sum_reg  <= '0;
            wall_reg <= '0;
            win_reg  <= '0;
        end

        if (state_reg == ST_TAP_A)
        begin
            tap_addr_reg <= tap_addr;
            tap_use_reg  <= tap_use;
            tap_in_reg   <= tap_in;
            w_reg        <= PROD_W'(vw_reg[a_abs]) * PROD_W'(hw_reg[b_abs]);
        end

        if (state_reg == ST_TAP_C)
        begin
            // Every tap counts towards the full weight sum; only in-image taps outside mirror
            // mode count towards the renormalizing sum.
            wall_reg <= wall_reg + DEN_W'(w_reg);
            if (fr_mode_reg != MODE_MIRROR && tap_in_reg)
            begin
                win_reg <= win_reg + DEN_W'(w_reg);
            end
            if (tap_use_reg)
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    sum_reg[ch] <= sum_reg[ch] +
                                   SUM_W'(w_reg) * SUM_W'(rd_data_reg[CH_W*ch +: CH_W]);
                end
            end
            if (b_reg == rad_s)
            begin
                b_reg <= -rad_s;
                a_reg <= a_reg + OFS_W'(1);
            end
            else
            begin
                b_reg <= b_reg + OFS_W'(1);
            end
            if (tap_last)
            begin
                if (fr_mode_reg == MODE_ADJUST)
                begin
                    denom_reg <= tap_in_reg ? win_reg + DEN_W'(w_reg) : win_reg;
                end
                else
                begin
                    denom_reg <= wall_reg + DEN_W'(w_reg);
                end
            end
        end

        if (div_done)
        begin
            res_px_reg   <= quot;
            res_last_reg <= out_last;
        end

        if (state_reg == ST_OUT && out_free)
        begin
            m_tdata_reg <= res_px_reg;
            m_tlast_reg <= res_last_reg;
        end
    end

    // Line store: one write port for incoming pixels, one registered tap read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[in_addr_reg] <= pend_px_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TAP_R)
        begin
            rd_data_reg <= line_mem[tap_addr_reg];
        end
    end

    gwf_div_chain #(
        .SUM_W (SUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start_reg),
        .sum_in (sum_reg),
        .denom  (denom_reg),
        .done   (div_done),
        .quot   (quot)
    );

    // The output position never runs ahead of the stored input.
    `GWF_ASSERT_IMP(a_out_behind_in, 1'b1, out_lin_reg <= in_lin_reg, "output position ahead of input")
    // A division result only arrives while the sequencer waits for it.
    `GWF_ASSERT_IMP(a_div_when_waiting, div_done, state_reg == ST_DIV, "division result out of turn")
    // Tap offsets stay inside the sampled window.
    `GWF_ASSERT_IMP(a_tap_in_window, state_reg == ST_TAP_A, (a_reg >= -rad_s) && (a_reg <= rad_s) && (b_reg >= -rad_s) && (b_reg <= rad_s), "tap offset outside window")
    // A result handed over to a free output register shows up as valid.
    `GWF_ASSERT_NXT(a_out_loaded, state_reg == ST_OUT && out_free, m_tvalid_reg, "result not presented")

endmodule

>>> rtl/gwf_div_cell.sv
// One restoring-division cell: settles one quotient bit for all channels.
module gwf_div_cell
    import gwf_pkg::*;
#(
    parameter int SUM_W = 46,
    parameter int DEN_W = 38,
    parameter int SHIFT = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             valid_in,
    input  logic [NUM_CH-1:0][SUM_W-1:0]     rem_in,
    input  logic [NUM_CH-1:0][QUOT_W-1:0]    q_in,
    input  logic [DEN_W-1:0]                 denom,
    output logic                             valid_out,
    output logic [NUM_CH-1:0][SUM_W-1:0]     rem_out,
    output logic [NUM_CH-1:0][QUOT_W-1:0]    q_out
);

    logic [SUM_W-1:0]                  dsh;
    logic [NUM_CH-1:0][SUM_W-1:0]      rem_next;
    logic [NUM_CH-1:0][QUOT_W-1:0]     q_next;
    logic                              valid_reg;
    logic [NUM_CH-1:0][SUM_W-1:0]      rem_reg;
    logic [NUM_CH-1:0][QUOT_W-1:0]     q_reg;

    assign dsh = SUM_W'(denom) << SHIFT;

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (rem_in[ch] >= dsh)
            begin
                rem_next[ch] = rem_in[ch] - dsh;
                q_next[ch]   = {q_in[ch][QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[ch] = rem_in[ch];
                q_next[ch]   = {q_in[ch][QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;

endmodule

>>> rtl/gwf_div_chain.sv
// Chain of division cells turning the three weighted sums into clamped channels.
module gwf_div_chain
    import gwf_pkg::*;
#(
    parameter int SUM_W = 46,
    parameter int DEN_W = 38
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_CH-1:0][SUM_W-1:0]  sum_in,
    input  logic [DEN_W-1:0]              denom,
    output logic                          done,
    output chan_t [NUM_CH-1:0]            quot
);

    logic [QUOT_W:0]                    vld;
    logic [NUM_CH-1:0][SUM_W-1:0]       rem  [QUOT_W+1];
    logic [NUM_CH-1:0][QUOT_W-1:0]      qv   [QUOT_W+1];

    assign vld[0] = start;
    assign rem[0] = sum_in;
    assign qv[0]  = '0;

    // The first cell tests the divisor shifted by eight places, so its bit
    // flags a quotient of 256 or more.
    for (genvar i = 0; i < QUOT_W; i++)
    begin : g_cell
        gwf_div_cell #(
            .SUM_W (SUM_W),
            .DEN_W (DEN_W),
            .SHIFT (QUOT_W - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (vld[i]),
            .rem_in    (rem[i]),
            .q_in      (qv[i]),
            .denom     (denom),
            .valid_out (vld[i+1]),
            .rem_out   (rem[i+1]),
            .q_out     (qv[i+1])
        );
    end

    assign done = vld[QUOT_W];

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (denom == '0)
            begin
                quot[ch] = '0;
            end
            else if (qv[QUOT_W][ch][QUOT_W-1])
            begin
                quot[ch] = '1;
            end
            else
            begin
                quot[ch] = qv[QUOT_W][ch][CH_W-1:0];
            end
        end
    end

endmodule
